/* hw/rtl/jraf_pkg.sv */
// shared types and codes for the j1939 receive acceptance filter
`timescale 1ns / 1ps

package jraf_pkg;

	localparam int ACTION_W = 2;
	localparam int REG_IDX_W = 3;
	localparam int REG_DATA_W = 64;
	localparam int S_TDATA_W = 264;
	localparam int M_TDATA_W = 8;

	localparam logic [ACTION_W-1:0] ACT_CLASSIFY = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ORIGIN_BUS = 2'd0;
	localparam logic [1:0] ORIGIN_SELF = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_MODE_FLAGS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOCAL_NAME = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LOCAL_ADDR = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PEER_NAME = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PEER_ADDR = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PGN_FILTER = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_IFACE_INDEX = 3'd6;

	localparam logic [7:0] ADDR_NONE = 8'd254;
	localparam logic [7:0] ADDR_UNICAST_MAX = 8'd253;
	localparam logic [18:0] PGN_FILTER_OFF = 19'h40000;

	typedef enum logic [1:0] {
		K_CLASSIFY,
		K_LOAD,
		K_CLEAR,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic pre_ok;
		logic dont_route;
		logic confirm;
		logic [17:0] pgn;
		logic [7:0] addr;
		logic [63:0] name;
		logic [17:0] pgn_care;
		logic [7:0] addr_care;
		logic [63:0] name_care;
	} cmd_t;

	typedef struct packed {
		logic accepted;
		logic dont_route;
		logic confirm;
		logic status;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* hw/rtl/j1939_receive_acceptance_filter.sv */
// top level of the j1939 receive acceptance filter
`timescale 1ns / 1ps
// Decides per received frame whether it is delivered to one endpoint.
// Input stream s_*: one transaction per item; tuser carries the action
// (classify frame, append filter entry, clear filter table), tdata the frame
// fields and, for appends, the filter masks. Output stream m_*: one
// transaction per input item with accepted, dont_route, confirm and status.
// Configuration registers are written through wr_en / wr_index / wr_data;
// the user must do so only with no item in flight; the block does not check it.
// An append, a clear, or a classify that fails the fixed checks or meets
// an empty table passes from the queue through the done state to the
// output register. A classify that reaches the filter table first scans
// the entries in order up to and including the first hit (all the
// entries loaded when none hits); the filter memory has one read port and
// yields one entry a cycle. The engine takes a new item only once the
// result of the last one has moved into the output register.
// A two-entry command queue takes new items while the table engine works.
// Reset clears the registers to their defaults and empties the table; the
// filter memory itself needs no clearing pass. When m_tready stays low the
// result is held, the engine waits, and s_tready falls once the queue fills.

module j1939_receive_acceptance_filter
	import jraf_pkg::*;
#(
	parameter int FILTER_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	input  logic s_tvalid,
	output logic s_tready,
	// frame_iface, frame_origin, frame_pgn, frame_src_addr, frame_dst_addr,
	// frame_src_name, frame_dst_name, load_pgn_mask, load_addr_mask,
	// load_name_mask, zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// action
	input  logic [ACTION_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// accepted, dont_route, confirm, status, zero fill
	output logic [M_TDATA_W-1:0] m_tdata
);

	cmd_t front_cmd;
	cmd_t q_cmd;
	logic q_valid;
	logic q_ready;
	qstat_t q_stat;
	res_t res;

	jraf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.action(s_tuser),
		.frame_iface(s_tdata[7:0]),
		.frame_origin(s_tdata[9:8]),
		.frame_pgn(s_tdata[27:10]),
		.frame_src_addr(s_tdata[35:28]),
		.frame_dst_addr(s_tdata[43:36]),
		.frame_src_name(s_tdata[107:44]),
		.frame_dst_name(s_tdata[171:108]),
		.load_pmask(s_tdata[189:172]),
		.load_amask(s_tdata[197:190]),
		.load_nmask(s_tdata[261:198]),
		.cmd(front_cmd)
	);

	jraf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(s_tvalid),
		.push_ready(s_tready),
		.push_cmd(front_cmd),
		.pop_valid(q_valid),
		.pop_ready(q_ready),
		.pop_cmd(q_cmd),
		.stat(q_stat)
	);

	jraf_back #(
		.FILTER_SLOTS(FILTER_SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_valid),
		.cmd_ready(q_ready),
		.cmd(q_cmd),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res(res)
	);

	assign m_tdata = {4'b0000, res.status, res.confirm, res.dont_route, res.accepted};

`ifndef SYNTHESIS
	a_confirm_routes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1])
		else $error("confirm without dont_route");

	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == 3'b000)
		else $error("table-full status on a classify result");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !s_tready && !q_stat.empty)
		else $error("full queue still taking items");
`endif

endmodule

/* hw/rtl/jraf_front.sv */
// front end: configuration registers and per-frame checks ahead of the filter table
`timescale 1ns / 1ps

module jraf_front
	import jraf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [REG_DATA_W-1:0] wr_data,
	input  logic [ACTION_W-1:0] action,
	input  logic [7:0] frame_iface,
	input  logic [1:0] frame_origin,
	input  logic [17:0] frame_pgn,
	input  logic [7:0] frame_src_addr,
	input  logic [7:0] frame_dst_addr,
	input  logic [63:0] frame_src_name,
	input  logic [63:0] frame_dst_name,
	input  logic [17:0] load_pmask,
	input  logic [7:0] load_amask,
	input  logic [63:0] load_nmask,
	output cmd_t cmd
);

	logic [4:0] mode_flags_q;
	logic [63:0] local_name_q;
	logic [7:0] local_addr_q;
	logic [63:0] peer_name_q;
	logic [7:0] peer_addr_q;
	logic [18:0] pgn_filter_q;
	logic [7:0] iface_index_q;

	logic self_c;
	logic dst_ok_c;
	logic src_ok_c;
	logic pgn_ok_c;
	logic route_ok_c;
	logic pre_ok_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_flags_q <= '0;
			local_name_q <= '0;
			local_addr_q <= ADDR_NONE;
			peer_name_q <= '0;
			peer_addr_q <= ADDR_NONE;
			pgn_filter_q <= PGN_FILTER_OFF;
			iface_index_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE_FLAGS: mode_flags_q <= wr_data[4:0];
				REG_LOCAL_NAME: local_name_q <= wr_data;
				REG_LOCAL_ADDR: local_addr_q <= wr_data[7:0];
				REG_PEER_NAME: peer_name_q <= wr_data;
				REG_PEER_ADDR: peer_addr_q <= wr_data[7:0];
				REG_PGN_FILTER: pgn_filter_q <= wr_data[18:0];
				REG_IFACE_INDEX: iface_index_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		self_c = (frame_origin == ORIGIN_SELF);
		if (local_name_q != '0 && frame_dst_name != '0) begin
			dst_ok_c = (local_name_q == frame_dst_name);
		end else if (frame_dst_addr <= ADDR_UNICAST_MAX) begin
			dst_ok_c = (local_addr_q == frame_dst_addr);
		end else begin
			dst_ok_c = mode_flags_q[4];
		end
		if (!mode_flags_q[1]) begin
			src_ok_c = 1'b1;
		end else if (peer_name_q != '0 && frame_src_name != '0) begin
			src_ok_c = (peer_name_q == frame_src_name);
		end else begin
			src_ok_c = (peer_addr_q == frame_src_addr);
		end
		pgn_ok_c = pgn_filter_q[18] || (pgn_filter_q[17:0] == frame_pgn);
		route_ok_c = mode_flags_q[2] || (dst_ok_c && src_ok_c && pgn_ok_c);
		pre_ok_c = (mode_flags_q[1:0] != 2'b00) && (iface_index_q == frame_iface)
			&& !(self_c && !mode_flags_q[3]) && route_ok_c;
	end

	always_comb begin
		cmd = '0;
		case (action)
			ACT_CLASSIFY: begin
				cmd.kind = K_CLASSIFY;
				cmd.pre_ok = pre_ok_c;
				cmd.dont_route = (frame_origin != ORIGIN_BUS);
				cmd.confirm = self_c;
				cmd.pgn = frame_pgn;
				cmd.addr = frame_src_addr;
				cmd.name = frame_src_name;
			end
			ACT_LOAD: begin
				cmd.kind = K_LOAD;
				cmd.pgn = frame_pgn & load_pmask;
				cmd.addr = frame_src_addr & load_amask;
				cmd.name = frame_src_name & load_nmask;
				cmd.pgn_care = load_pmask;
				cmd.addr_care = load_amask;
				cmd.name_care = load_nmask;
			end
			ACT_CLEAR: cmd.kind = K_CLEAR;
			default: cmd.kind = K_NOP;
		endcase
	end

endmodule

/* hw/rtl/jraf_queue.sv */
// two-entry command queue between front end and table engine
`timescale 1ns / 1ps

module jraf_queue
	import jraf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd,
	output qstat_t stat
);

	cmd_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] fill_q;

	logic push_c;
	logic pop_c;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_cmd = slot_q[rd_ptr_q];
	assign push_c = push_valid && push_ready;
	assign pop_c = pop_valid && pop_ready;
	assign stat.full = (fill_q == 2'd2);
	assign stat.empty = (fill_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push_c) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push_c) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop_c) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push_c, pop_c})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/jraf_back.sv */
// table engine: filter memory, load and clear, one entry compared per cycle
`timescale 1ns / 1ps

module jraf_back
	import jraf_pkg::*;
#(
	parameter int FILTER_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
	localparam int CNT_W = $clog2(FILTER_SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(FILTER_SLOTS);

	typedef struct packed {
		logic [17:0] pgn_value;
		logic [17:0] pgn_care;
		logic [7:0] addr_value;
		logic [7:0] addr_care;
		logic [63:0] name_value;
		logic [63:0] name_care;
	} flt_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DONE
	} state_t;

	flt_t mem [FILTER_SLOTS];
	flt_t rdata_q;
	flt_t wr_entry_c;

	state_t state_q;
	cmd_t cmd_q;
	res_t res_q;
	res_t out_q;
	logic out_valid_q;
	logic rvalid_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;

	logic pop_c;
	logic full_c;
	logic wr_en_c;
	logic rd_en_c;
	logic match_c;
	logic scan_c;
	logic out_load_c;
	res_t pop_res_c;

	assign cmd_ready = (state_q == B_IDLE);
	assign pop_c = cmd_valid && cmd_ready;
	assign full_c = (count_q == SLOTS_CNT);
	assign wr_en_c = pop_c && (cmd.kind == K_LOAD) && !full_c;
	assign res_valid = out_valid_q;
	assign res = out_q;
	assign scan_c = (cmd.kind == K_CLASSIFY) && cmd.pre_ok && (count_q != '0);
	assign out_load_c = (state_q == B_DONE) && (!out_valid_q || res_ready);

	assign match_c = rvalid_q
		&& ((cmd_q.pgn & rdata_q.pgn_care) == rdata_q.pgn_value)
		&& ((cmd_q.addr & rdata_q.addr_care) == rdata_q.addr_value)
		&& ((cmd_q.name & rdata_q.name_care) == rdata_q.name_value);
	assign rd_en_c = (state_q == B_SCAN) && !match_c && (issue_q != count_q);

	always_comb begin
		wr_entry_c.pgn_value = cmd.pgn;
		wr_entry_c.pgn_care = cmd.pgn_care;
		wr_entry_c.addr_value = cmd.addr;
		wr_entry_c.addr_care = cmd.addr_care;
		wr_entry_c.name_value = cmd.name;
		wr_entry_c.name_care = cmd.name_care;
	end

	always_comb begin
		pop_res_c = '0;
		case (cmd.kind)
			K_CLASSIFY: begin
				pop_res_c.accepted = cmd.pre_ok && (count_q == '0);
				pop_res_c.dont_route = cmd.dont_route;
				pop_res_c.confirm = cmd.confirm;
			end
			K_LOAD: pop_res_c.status = full_c;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en_c) begin
			mem[count_q[IDX_W-1:0]] <= wr_entry_c;
		end
		if (rd_en_c) begin
			rdata_q <= mem[issue_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cmd_q <= '0;
			res_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
			rvalid_q <= 1'b0;
			count_q <= '0;
			issue_q <= '0;
		end else begin
			if (out_load_c) begin
				out_q <= res_q;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_c) begin
						cmd_q <= cmd;
						res_q <= pop_res_c;
						issue_q <= '0;
						rvalid_q <= 1'b0;
						state_q <= scan_c ? B_SCAN : B_DONE;
						if (cmd.kind == K_LOAD && !full_c) begin
							count_q <= count_q + CNT_W'(1);
						end else if (cmd.kind == K_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				B_SCAN: begin
					if (match_c) begin
						res_q.accepted <= 1'b1;
						rvalid_q <= 1'b0;
						state_q <= B_DONE;
					end else if (issue_q == count_q) begin
						rvalid_q <= 1'b0;
						state_q <= B_DONE;
					end else begin
						rvalid_q <= 1'b1;
						issue_q <= issue_q + CNT_W'(1);
					end
				end
				B_DONE: begin
					if (out_load_c) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

/* verif/testbench.sv */
// testbench for the j1939 receive acceptance filter: directed and random items checked by a predictor
`timescale 1ns / 1ps

module testbench;
	import jraf_pkg::*;

	localparam int FILTER_SLOTS = 16;
	localparam int PERIOD = 12;
	localparam int RESET_CYCLES = 11;
	localparam int DRAIN_CYCLES = 24;
	localparam int STUCK_LIMIT = 3000;
	localparam int STALL_CYCLES = 80;
	localparam int PRINT_CAP = 100;

	localparam logic [1:0] ORIGIN_OTHER_LOCAL = 2'd1;
	localparam logic [1:0] ORIGIN_RESERVED = 2'd3;
	localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_RESERVED = 3'd7;

	localparam logic [4:0] MODE_BOUND = 5'b00001;
	localparam logic [4:0] MODE_CONN = 5'b00010;
	localparam logic [4:0] MODE_PROMISC = 5'b00100;
	localparam logic [4:0] MODE_RECV_OWN = 5'b01000;
	localparam logic [4:0] MODE_BCAST = 5'b10000;

	localparam int RES_ACCEPTED = 0;
	localparam int RES_DONT_ROUTE = 1;
	localparam int RES_CONFIRM = 2;
	localparam int RES_STATUS = 3;

	typedef struct packed {
		logic [1:0] pad;
		logic [63:0] nmask;
		logic [7:0] amask;
		logic [17:0] pmask;
		logic [63:0] dname;
		logic [63:0] sname;
		logic [7:0] da;
		logic [7:0] sa;
		logic [17:0] pgn;
		logic [1:0] origin;
		logic [7:0] iface;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [ACTION_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// endpoint registers as the block should hold them
	logic [4:0] cfg_mode = '0;
	logic [63:0] cfg_lname = '0;
	logic [7:0] cfg_laddr = ADDR_NONE;
	logic [63:0] cfg_pname = '0;
	logic [7:0] cfg_paddr = ADDR_NONE;
	logic [18:0] cfg_pgn = PGN_FILTER_OFF;
	logic [7:0] cfg_iface = '0;

	// filter table as the block should hold it
	logic [17:0] tbl_pv [FILTER_SLOTS];
	logic [17:0] tbl_pm [FILTER_SLOTS];
	logic [7:0] tbl_av [FILTER_SLOTS];
	logic [7:0] tbl_am [FILTER_SLOTS];
	logic [63:0] tbl_nv [FILTER_SLOTS];
	logic [63:0] tbl_nm [FILTER_SLOTS];
	int tbl_cnt = 0;

	res_t verdict_q [$];
	int err_cnt = 0;
	int res_cnt = 0;
	int stuck_cnt = 0;
	int stall_left = 0;
	bit no_idle = 1'b0;

	j1939_receive_acceptance_filter #(
		.FILTER_SLOTS(FILTER_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #(PERIOD / 2) clk = ~clk;

	task automatic report(input string msg);
		if (err_cnt < PRINT_CAP)
			$display("mismatch: %s", msg);
		err_cnt++;
	endtask

	function automatic void model_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] v);
		case (idx)
			REG_MODE_FLAGS: cfg_mode = v[4:0];
			REG_LOCAL_NAME: cfg_lname = v;
			REG_LOCAL_ADDR: cfg_laddr = v[7:0];
			REG_PEER_NAME: cfg_pname = v;
			REG_PEER_ADDR: cfg_paddr = v[7:0];
			REG_PGN_FILTER: cfg_pgn = v[18:0];
			REG_IFACE_INDEX: cfg_iface = v[7:0];
			default: ;
		endcase
	endfunction

	function automatic logic route_ok(input frame_t f);
		if ((cfg_mode & MODE_PROMISC) != '0)
			return 1'b1;
		if (cfg_lname != '0 && f.dname != '0) begin
			if (cfg_lname != f.dname)
				return 1'b0;
		end else if (f.da <= ADDR_UNICAST_MAX) begin
			if (cfg_laddr != f.da)
				return 1'b0;
		end else if ((cfg_mode & MODE_BCAST) == '0) begin
			return 1'b0;
		end
		if ((cfg_mode & MODE_CONN) != '0) begin
			if (cfg_pname != '0 && f.sname != '0) begin
				if (cfg_pname != f.sname)
					return 1'b0;
			end else if (cfg_paddr != f.sa) begin
				return 1'b0;
			end
		end
		if (cfg_pgn < PGN_FILTER_OFF && cfg_pgn != {1'b0, f.pgn})
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic table_hit(input frame_t f);
		if (tbl_cnt == 0)
			return 1'b1;
		for (int i = 0; i < tbl_cnt; i++) begin
			if ((f.pgn & tbl_pm[i]) == tbl_pv[i] && (f.sa & tbl_am[i]) == tbl_av[i] &&
					(f.sname & tbl_nm[i]) == tbl_nv[i])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// works out the result of one item and advances the filter table
	function automatic res_t predict_verdict(input logic [ACTION_W-1:0] act, input frame_t f);
		res_t r;
		r = '0;
		case (act)
			ACT_CLASSIFY: begin
				r.dont_route = f.origin != ORIGIN_BUS;
				r.confirm = f.origin == ORIGIN_SELF;
				if ((cfg_mode & (MODE_BOUND | MODE_CONN)) == '0)
					r.accepted = 1'b0;
				else if (f.iface != cfg_iface)
					r.accepted = 1'b0;
				else if (r.confirm && (cfg_mode & MODE_RECV_OWN) == '0)
					r.accepted = 1'b0;
				else
					r.accepted = route_ok(f) && table_hit(f);
			end
			ACT_LOAD: begin
				if (tbl_cnt >= FILTER_SLOTS) begin
					r.status = 1'b1;
				end else begin
					tbl_pv[tbl_cnt] = f.pgn & f.pmask;
					tbl_pm[tbl_cnt] = f.pmask;
					tbl_av[tbl_cnt] = f.sa & f.amask;
					tbl_am[tbl_cnt] = f.amask;
					tbl_nv[tbl_cnt] = f.sname & f.nmask;
					tbl_nm[tbl_cnt] = f.nmask;
					tbl_cnt++;
				end
			end
			ACT_CLEAR: tbl_cnt = 0;
			default: ;
		endcase
		return r;
	endfunction

	// results, register writes and accepted items, all seen at the rising edge
	always @(posedge clk) begin
		frame_t fr;
		res_t want;
		if (m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				report($sformatf("result %0d with nothing expected, data %h", res_cnt, m_tdata));
			end else begin
				want = verdict_q.pop_front();
				if (m_tdata[RES_ACCEPTED] !== want.accepted)
					report($sformatf("result %0d accepted got %b expected %b", res_cnt,
						m_tdata[RES_ACCEPTED], want.accepted));
				if (m_tdata[RES_DONT_ROUTE] !== want.dont_route)
					report($sformatf("result %0d dont_route got %b expected %b", res_cnt,
						m_tdata[RES_DONT_ROUTE], want.dont_route));
				if (m_tdata[RES_CONFIRM] !== want.confirm)
					report($sformatf("result %0d confirm got %b expected %b", res_cnt,
						m_tdata[RES_CONFIRM], want.confirm));
				if (m_tdata[RES_STATUS] !== want.status)
					report($sformatf("result %0d status got %b expected %b", res_cnt,
						m_tdata[RES_STATUS], want.status));
			end
			res_cnt++;
		end
		if (wr_en)
			model_write(wr_index, wr_data);
		if (s_tvalid && s_tready) begin
			fr = s_tdata;
			verdict_q.push_back(predict_verdict(s_tuser, fr));
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cnt = 0;
		else
			stuck_cnt++;
		if (stuck_cnt >= STUCK_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 27);
		end
	end

	function automatic logic [63:0] pick_mask();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom};
			default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		f.pad = '0;
		f.nmask = {$urandom, $urandom};
		f.amask = 8'($urandom);
		f.pmask = 18'($urandom);
		f.dname = {$urandom, $urandom};
		f.sname = {$urandom, $urandom};
		f.da = 8'($urandom);
		f.sa = 8'($urandom);
		f.pgn = 18'($urandom);
		f.origin = 2'($urandom_range(0, 3));
		f.iface = 8'($urandom);
		return f;
	endfunction

	// steers a random frame toward the paths that get past the early checks
	function automatic frame_t shape_classify(input frame_t f);
		int k;
		if ($urandom_range(99) < 85)
			f.iface = cfg_iface;
		case ($urandom_range(0, 4))
			0: f.dname = cfg_lname;
			1: begin
				f.dname = '0;
				f.da = cfg_laddr;
			end
			2: begin
				f.dname = '0;
				f.da = 8'($urandom_range(254, 255));
			end
			3: f.da = cfg_laddr;
			default: ;
		endcase
		if (tbl_cnt > 0 && $urandom_range(99) < 70) begin
			k = $urandom_range(0, tbl_cnt - 1);
			f.pgn = tbl_pv[k] | (f.pgn & ~tbl_pm[k]);
			f.sa = tbl_av[k] | (f.sa & ~tbl_am[k]);
			f.sname = tbl_nv[k] | (f.sname & ~tbl_nm[k]);
		end
		if ((cfg_mode & MODE_CONN) != '0 && $urandom_range(99) < 75) begin
			if ($urandom_range(1) == 1) begin
				f.sname = cfg_pname;
			end else begin
				f.sname = '0;
				f.sa = cfg_paddr;
			end
		end
		if (cfg_pgn < PGN_FILTER_OFF && $urandom_range(99) < 75)
			f.pgn = cfg_pgn[17:0];
		return f;
	endfunction

	function automatic frame_t shape_load(input frame_t f);
		f.pmask = pick_mask();
		f.amask = pick_mask();
		f.nmask = pick_mask();
		if (cfg_pgn < PGN_FILTER_OFF && $urandom_range(99) < 30)
			f.pgn = cfg_pgn[17:0];
		return f;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [ACTION_W-1:0] act, input frame_t f);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(99) < 27)
			gap = $urandom_range(1, ($urandom_range(9) == 0) ? 24 : 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= f;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic classify_frame(input logic [7:0] iface, input logic [1:0] origin,
			input logic [17:0] pgn, input logic [7:0] sa, input logic [7:0] da,
			input logic [63:0] sname, input logic [63:0] dname);
		frame_t f;
		f = rand_frame();
		f.iface = iface;
		f.origin = origin;
		f.pgn = pgn;
		f.sa = sa;
		f.da = da;
		f.sname = sname;
		f.dname = dname;
		send_item(ACT_CLASSIFY, f);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [4:0] mode, input logic [63:0] lname,
			input logic [7:0] laddr, input logic [63:0] pname, input logic [7:0] paddr,
			input logic [18:0] pgn, input logic [7:0] iface);
		wait_idle();
		write_reg(REG_MODE_FLAGS, 64'(mode));
		write_reg(REG_LOCAL_NAME, lname);
		write_reg(REG_LOCAL_ADDR, 64'(laddr));
		write_reg(REG_PEER_NAME, pname);
		write_reg(REG_PEER_ADDR, 64'(paddr));
		write_reg(REG_PGN_FILTER, 64'(pgn));
		write_reg(REG_IFACE_INDEX, 64'(iface));
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_config();
		logic [4:0] mode;
		logic [18:0] pgn;
		mode = 5'($urandom);
		if ($urandom_range(99) < 60)
			mode &= ~MODE_PROMISC;
		if ($urandom_range(99) < 80)
			mode |= ($urandom_range(1) == 1) ? MODE_BOUND : MODE_CONN;
		case ($urandom_range(0, 3))
			0, 1: pgn = PGN_FILTER_OFF;
			2: pgn = ($urandom_range(4) == 0) ? 19'h7FFFF : 19'($urandom);
			default: pgn = {1'b0, 18'($urandom)};
		endcase
		apply_config(mode,
			($urandom_range(2) == 0) ? 64'd0 : {$urandom, $urandom},
			($urandom_range(3) == 0) ? ADDR_NONE : 8'($urandom),
			($urandom_range(2) == 0) ? 64'd0 : {$urandom, $urandom},
			($urandom_range(3) == 0) ? ADDR_NONE : 8'($urandom),
			pgn, 8'($urandom));
	endtask

	task automatic run_items(input int n, input int load_pct, input int clear_pct);
		int r;
		frame_t f;
		repeat (n) begin
			r = $urandom_range(99);
			f = rand_frame();
			if (r < load_pct)
				send_item(ACT_LOAD, shape_load(f));
			else if (r < load_pct + clear_pct)
				send_item(ACT_CLEAR, f);
			else if (r < load_pct + clear_pct + 3)
				send_item(ACT_RESERVED, f);
			else
				send_item(ACT_CLASSIFY, shape_classify(f));
		end
	endtask

	// defaults after reset: not bound, so nothing is delivered; unused action
	task automatic test_reset_defaults();
		frame_t f;
		classify_frame('0, ORIGIN_SELF, '0, '0, '0, '0, '0);
		f = '1;
		f.pad = '0;
		send_item(ACT_RESERVED, f);
	endtask

	task automatic test_endpoint_checks();
		apply_config(MODE_BOUND, '1, 8'd0, '0, ADDR_NONE, PGN_FILTER_OFF, 8'hFF);
		classify_frame(8'h00, ORIGIN_BUS, '0, '0, 8'd0, '0, '0);
		classify_frame(8'hFF, ORIGIN_BUS, '1, '1, 8'd0, '0, '0);
		classify_frame(8'hFF, ORIGIN_SELF, '0, '0, 8'd0, '0, '0);
		classify_frame(8'hFF, ORIGIN_RESERVED, '0, '0, 8'd0, '0, '0);
		classify_frame(8'hFF, ORIGIN_BUS, '0, '0, 8'd77, '0, '1);
		classify_frame(8'hFF, ORIGIN_OTHER_LOCAL, '0, '0, 8'd0, '0, 64'd1);
		classify_frame(8'hFF, ORIGIN_BUS, '0, '0, 8'hFF, '0, '0);
	endtask

	task automatic test_connected_pgn();
		logic [63:0] peer;
		peer = 64'h8000_0000_0000_0001;
		apply_config(MODE_CONN | MODE_RECV_OWN | MODE_BCAST, '0, ADDR_UNICAST_MAX, peer, 8'hFF,
			19'h3FFFF, 8'h00);
		classify_frame(8'h00, ORIGIN_SELF, '1, 8'hFF, 8'hFF, '0, '1);
		classify_frame(8'h00, ORIGIN_SELF, '0, 8'hFF, 8'hFF, '0, '1);
		classify_frame(8'h00, ORIGIN_BUS, '1, 8'h00, ADDR_NONE, peer, '0);
		classify_frame(8'h00, ORIGIN_BUS, '1, 8'hFF, ADDR_UNICAST_MAX, 64'd2, '0);
	endtask

	task automatic test_filter_table();
		frame_t f;
		apply_config('1, {$urandom, $urandom}, 8'($urandom), {$urandom, $urandom},
			8'($urandom), 19'h7FFFF, 8'h00);
		f = rand_frame();
		f.pgn = '1;
		f.sa = '1;
		f.sname = '1;
		f.pmask = '1;
		f.amask = '1;
		f.nmask = '1;
		send_item(ACT_LOAD, f);
		classify_frame(8'h00, ORIGIN_BUS, '1, 8'hFF, 8'($urandom), '1, {$urandom, $urandom});
		classify_frame(8'h00, ORIGIN_BUS, 18'h3FFFE, 8'hFF, 8'($urandom), '1, '0);
		send_item(ACT_CLEAR, rand_frame());
		classify_frame(8'h00, ORIGIN_BUS, 18'h3FFFE, 8'hFF, 8'($urandom), '1, '0);
	endtask

	task automatic test_table_overflow();
		apply_config(MODE_BOUND | MODE_PROMISC, '0, ADDR_NONE, '0, ADDR_NONE, PGN_FILTER_OFF,
			8'($urandom));
		send_item(ACT_CLEAR, rand_frame());
		repeat (FILTER_SLOTS + 2) send_item(ACT_LOAD, shape_load(rand_frame()));
		run_items(10, 0, 0);
	endtask

	task automatic test_backpressure();
		wait_idle();
		no_idle = 1'b1;
		stall_left <= STALL_CYCLES;
		run_items(14, 10, 5);
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		wait_idle();
		write_reg(REG_RESERVED, {$urandom, $urandom});
		wr_en <= 1'b0;
		@(negedge clk);
		for (int ph = 0; ph < 7; ph++) begin
			random_config();
			no_idle = (ph == 3);
			if (ph == 5)
				run_items(115, 35, 1);
			else
				run_items(115, 12, 4);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_endpoint_checks();
		test_connected_pgn();
		test_filter_table();
		test_table_overflow();
		test_backpressure();
		test_random();
		wait_idle();
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
